[hdl/lhq_pkg.sv]
package lhq_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int VAL_W      = 32;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic                    is_query;
        logic [CNT_W-1:0]        xc;
        logic signed [VAL_W-1:0] yc;
        logic signed [VAL_W-1:0] slope;
    } t_cmp_ctl;

endpackage

[hdl/lhq_if.sv]
interface lhq_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       command;
    logic signed [lhq_pkg::VAL_W-1:0] point_value;
    logic signed [lhq_pkg::VAL_W-1:0] query_slope;

    modport source (output valid, output command, output point_value,
                    output query_slope, input ready);
    modport sink   (input valid, input command, input point_value,
                    input query_slope, output ready);
endinterface

interface lhq_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [lhq_pkg::IDX_W-1:0] best_index;
    logic [1:0]                status;
    logic [lhq_pkg::CNT_W-1:0] hull_count;

    modport source (output valid, output best_index, output status,
                    output hull_count, input ready);
    modport sink   (input valid, input best_index, input status,
                    input hull_count, output ready);
endinterface

[hdl/lhq_mem.sv]
module lhq_mem (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [lhq_pkg::IDX_W-1:0] i_waddr,
    input  lhq_pkg::t_entry           i_wdata,
    input  logic [lhq_pkg::IDX_W-1:0] i_raddr_a,
    input  logic [lhq_pkg::IDX_W-1:0] i_raddr_b,
    output lhq_pkg::t_entry           o_rdata_a,
    output lhq_pkg::t_entry           o_rdata_b
);

    lhq_pkg::t_entry r_mem [lhq_pkg::MAX_POINTS];
    lhq_pkg::t_entry r_rd_a;
    lhq_pkg::t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

[hdl/lhq_cmp.sv]
module lhq_cmp (
    input  logic              i_clk,
    input  lhq_pkg::t_cmp_ctl i_ctl,
    input  lhq_pkg::t_entry   i_ent_a,
    input  lhq_pkg::t_entry   i_ent_b,
    output logic              o_flag
);

    localparam int VW = lhq_pkg::VAL_W;
    localparam int IW = lhq_pkg::IDX_W;
    localparam int DW = VW + 1;
    localparam int XW = IW + 2;
    localparam int PW = DW + XW;

    logic signed [DW-1:0] op1a;
    logic signed [DW-1:0] op2a;
    logic signed [XW-1:0] op1b;
    logic signed [XW-1:0] op2b;
    logic signed [PW-1:0] n_p1;
    logic signed [PW-1:0] n_p2;
    logic signed [PW-1:0] r_p1;
    logic signed [PW-1:0] r_p2;
    logic signed [VW-1:0] r_ya;
    logic signed [VW-1:0] r_yb;
    logic                 r_query;
    logic signed [PW:0]   v1;
    logic signed [PW:0]   v2;

    always_comb begin
        if (i_ctl.is_query) begin
            op1a = $signed({i_ctl.slope[VW-1], i_ctl.slope});
            op2a = $signed({i_ctl.slope[VW-1], i_ctl.slope});
            op1b = $signed({2'b00, i_ent_a.idx});
            op2b = $signed({2'b00, i_ent_b.idx});
        end else begin
            op1a = $signed({i_ent_b.value[VW-1], i_ent_b.value})
                 - $signed({i_ent_a.value[VW-1], i_ent_a.value});
            op2a = $signed({i_ctl.yc[VW-1], i_ctl.yc})
                 - $signed({i_ent_b.value[VW-1], i_ent_b.value});
            op1b = $signed({1'b0, i_ctl.xc}) - $signed({2'b00, i_ent_b.idx});
            op2b = $signed({2'b00, i_ent_b.idx}) - $signed({2'b00, i_ent_a.idx});
        end
        n_p1 = op1a * op1b;
        n_p2 = op2a * op2b;
    end

    always_ff @(posedge i_clk) begin
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_ya    <= i_ent_a.value;
        r_yb    <= i_ent_b.value;
        r_query <= i_ctl.is_query;
    end

    always_comb begin
        v1 = $signed({{(PW + 1 - VW){r_ya[VW-1]}}, r_ya}) + $signed({r_p1[PW-1], r_p1});
        v2 = $signed({{(PW + 1 - VW){r_yb[VW-1]}}, r_yb}) + $signed({r_p2[PW-1], r_p2});
        o_flag = r_query ? (v1 <= v2) : (r_p1 >= r_p2);
    end

endmodule

[hdl/lower_hull_min_query_unit.sv]
// Lower-hull minimum query: keeps the lower convex hull of points (i, A[i]) in an on-chip
// memory, with i taken from an internal counter, and answers "which index minimizes
// A[i] + C*i" by binary search over the hull. One request is in work at a time; a result
// waits in an output register, so the next request is taken while it is unread. Clear,
// dropped adds, queries on an empty hull and unused codes go straight to the done state. An
// add pops hull tops (k of them, amortized constant) until fewer than two points are left
// or a pop test keeps the top, then writes the point; a query binary-searches the hull.
// Each pop test or search step is one memory read of two entries, one registered multiply
// pair and one compare. A result that is not taken holds the block in its done state.
// Clear the hull before the first use is not needed: reset leaves it empty.
module lower_hull_min_query_unit (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lhq_req_if.sink   i_req,
    lhq_rsp_if.source o_rsp
);

    localparam int IW = lhq_pkg::IDX_W;
    localparam int CW = lhq_pkg::CNT_W;
    localparam logic [CW-1:0] CntOne  = {{(CW - 1){1'b0}}, 1'b1};
    localparam logic [CW-1:0] CntTwo  = {{(CW - 2){1'b0}}, 2'b10};
    localparam logic [CW-1:0] CntFull = CW'(lhq_pkg::MAX_POINTS);
    localparam logic [IW-1:0] IdxOne  = {{(IW - 1){1'b0}}, 1'b1};

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_CHK, S_ADD_MUL, S_ADD_DEC, S_PUSH,
        S_Q_CHK, S_Q_MUL, S_Q_DEC, S_Q_FIN, S_DONE
    } t_state;

    t_state                          r_state;
    logic [CW-1:0]                   r_size;
    logic [CW-1:0]                   r_next;
    logic                            r_is_query;
    logic signed [lhq_pkg::VAL_W-1:0] r_yc;
    logic signed [lhq_pkg::VAL_W-1:0] r_slope;
    logic [IW-1:0]                   r_lo;
    logic [IW-1:0]                   r_hi;
    logic [IW-1:0]                   r_best;
    logic [1:0]                      r_status;
    logic                            r_out_valid;
    logic [IW-1:0]                   r_out_best;
    logic [1:0]                      r_out_status;
    logic [CW-1:0]                   r_out_count;

    logic [CW-1:0]     size_m1;
    logic [CW-1:0]     size_m2;
    logic [CW-1:0]     mid_sum;
    logic [IW-1:0]     mid;
    logic [IW-1:0]     mid_p1;
    logic [IW-1:0]     addr_a;
    logic [IW-1:0]     addr_b;
    logic              mem_we;
    lhq_pkg::t_entry   wdata;
    lhq_pkg::t_entry   rdata_a;
    lhq_pkg::t_entry   rdata_b;
    lhq_pkg::t_cmp_ctl cmp_ctl;
    logic              cmp_flag;

    assign size_m1 = r_size - CntOne;
    assign size_m2 = r_size - CntTwo;
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW-1:1];
    assign mid_p1  = mid + IdxOne;

    always_comb begin
        addr_a = '0;
        addr_b = '0;
        unique case (r_state)
            S_ADD_CHK: begin
                addr_a = size_m2[IW-1:0];
                addr_b = size_m1[IW-1:0];
            end
            S_Q_CHK: begin
                addr_a = (r_lo == r_hi) ? r_lo : mid;
                addr_b = mid_p1;
            end
            default: begin
                addr_a = '0;
                addr_b = '0;
            end
        endcase
    end

    assign mem_we      = (r_state == S_PUSH);
    assign wdata.idx   = r_next[IW-1:0];
    assign wdata.value = r_yc;

    assign cmp_ctl.is_query = r_is_query;
    assign cmp_ctl.xc       = r_next;
    assign cmp_ctl.yc       = r_yc;
    assign cmp_ctl.slope    = r_slope;

    lhq_mem u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (r_size[IW-1:0]),
        .i_wdata   (wdata),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    lhq_cmp u_cmp (
        .i_clk   (i_clk),
        .i_ctl   (cmp_ctl),
        .i_ent_a (rdata_a),
        .i_ent_b (rdata_b),
        .o_flag  (cmp_flag)
    );

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.best_index = r_out_best;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.hull_count = r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= '0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_yc       <= i_req.point_value;
                        r_slope    <= i_req.query_slope;
                        r_is_query <= (i_req.command == lhq_pkg::CMD_QUERY);
                        r_best     <= '0;
                        r_status   <= lhq_pkg::ST_OK;
                        r_lo       <= '0;
                        r_hi       <= size_m1[IW-1:0];
                        r_state    <= S_DONE;
                        case (i_req.command)
                            lhq_pkg::CMD_CLEAR: begin
                                r_size <= '0;
                                r_next <= '0;
                            end
                            lhq_pkg::CMD_ADD: begin
                                if (r_next == CntFull) begin
                                    r_status <= lhq_pkg::ST_FULL;
                                end else begin
                                    r_state <= S_ADD_CHK;
                                end
                            end
                            lhq_pkg::CMD_QUERY: begin
                                if (r_size == '0) begin
                                    r_status <= lhq_pkg::ST_EMPTY;
                                end else begin
                                    r_state <= S_Q_CHK;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_ADD_CHK: begin
                    r_state <= (r_size < CntTwo) ? S_PUSH : S_ADD_MUL;
                end
                S_ADD_MUL: begin
                    r_state <= S_ADD_DEC;
                end
                S_ADD_DEC: begin
                    if (cmp_flag) begin
                        r_size  <= size_m1;
                        r_state <= S_ADD_CHK;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_size  <= r_size + CntOne;
                    r_next  <= r_next + CntOne;
                    r_state <= S_DONE;
                end
                S_Q_CHK: begin
                    r_state <= (r_lo == r_hi) ? S_Q_FIN : S_Q_MUL;
                end
                S_Q_MUL: begin
                    r_state <= S_Q_DEC;
                end
                S_Q_DEC: begin
                    if (cmp_flag) begin
                        r_hi <= mid;
                    end else begin
                        r_lo <= mid_p1;
                    end
                    r_state <= S_Q_CHK;
                end
                S_Q_FIN: begin
                    r_best  <= rdata_a.idx;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_best   <= r_best;
                        r_out_status <= r_status;
                        r_out_count  <= r_size;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
